### rtl/core/ppam_pkg.sv
package ppam_pkg;

   // Coordinate width is fixed by the payload fields
   localparam int COORD_BITS   = 12;
   localparam int SIZE_BITS    = COORD_BITS + 1;
   localparam int CSR_IDX_BITS = 3;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ROW0   = 3'd0,
      CSR_ROW1   = 3'd1,
      CSR_ROW2   = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4,
      CSR_DIR    = 3'd5,
      CSR_SPARE  = 3'd7    // no register behind it, writes are dropped
   } ppam_csr_type;

   localparam logic DIR_INVERSE = 1'b1;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_row;
      logic [COORD_BITS-1:0] pixel_col;
   } ppam_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] mapped_row;
      logic [COORD_BITS-1:0] mapped_col;
      logic                  write_zero;
      logic                  denom_zero;
   } ppam_rsp_type;

   // Saturation flags that ride along the divider
   typedef struct packed {
      logic col_hi;
      logic col_lo;
      logic row_hi;
      logic row_lo;
      logic denom_zero;
   } ppam_side_type;

endpackage

### rtl/core/ppam_proj.sv
module ppam_proj import ppam_pkg::*; #(
   parameter int CW = 21,
   parameter int PW = CW + COORD_BITS + 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  ppam_req_type       in_data,
   input  logic [3*CW-1:0]    coef0,
   input  logic [3*CW-1:0]    coef1,
   input  logic [3*CW-1:0]    coef2,
   output logic               out_vld,
   output logic [PW-1:0]      out_abs_col,
   output logic [PW-1:0]      out_abs_row,
   output logic [PW-1:0]      out_abs_den,
   output ppam_side_type      out_side
);

   localparam int PRW = CW + COORD_BITS + 1;

   logic [3*CW-1:0]        coef_row [3];
   logic signed [PRW-1:0]  prod_in  [3][3];
   logic signed [PRW-1:0]  prod_ff  [3][3];
   logic signed [PW-1:0]   sum_in   [3];
   logic signed [PW-1:0]   sum_ff   [3];
   logic [2:0]             vld_ff;
   logic [PW-1:0]          abs_col_ff, abs_row_ff, abs_den_ff;
   ppam_side_type          side_in, side_ff;
   logic signed [COORD_BITS:0] col_s, row_s;

   assign coef_row[0] = coef0;
   assign coef_row[1] = coef1;
   assign coef_row[2] = coef2;
   assign col_s = $signed({1'b0, in_data.pixel_col});
   assign row_s = $signed({1'b0, in_data.pixel_row});

   // stage 1: six products and the constant terms
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = $signed(coef_row[r][0 +: CW]) * col_s;
         prod_in[r][1] = $signed(coef_row[r][CW +: CW]) * row_s;
         prod_in[r][2] = PRW'($signed(coef_row[r][2*CW +: CW]));
      end
   end

   // stage 2: projective terms
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = $signed({{(PW-PRW){prod_ff[r][0][PRW-1]}}, prod_ff[r][0]})
                   + $signed({{(PW-PRW){prod_ff[r][1][PRW-1]}}, prod_ff[r][1]})
                   + $signed({{(PW-PRW){prod_ff[r][2][PRW-1]}}, prod_ff[r][2]});
      end
   end

   // stage 3: sign handling, saturation cases
   always_comb begin
      side_in.denom_zero = (sum_ff[2] == '0);
      side_in.col_hi = side_in.denom_zero && !sum_ff[0][PW-1] && (sum_ff[0] != '0);
      side_in.row_hi = side_in.denom_zero && !sum_ff[1][PW-1] && (sum_ff[1] != '0);
      side_in.col_lo = side_in.denom_zero ? !side_in.col_hi
                                          : (sum_ff[0][PW-1] != sum_ff[2][PW-1]);
      side_in.row_lo = side_in.denom_zero ? !side_in.row_hi
                                          : (sum_ff[1][PW-1] != sum_ff[2][PW-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         sum_ff     <= sum_in;
         abs_col_ff <= sum_ff[0][PW-1] ? PW'(-sum_ff[0]) : sum_ff[0];
         abs_row_ff <= sum_ff[1][PW-1] ? PW'(-sum_ff[1]) : sum_ff[1];
         abs_den_ff <= sum_ff[2][PW-1] ? PW'(-sum_ff[2]) : sum_ff[2];
         side_ff    <= side_in;
      end
   end

   assign out_vld     = vld_ff[2];
   assign out_abs_col = abs_col_ff;
   assign out_abs_row = abs_row_ff;
   assign out_abs_den = abs_den_ff;
   assign out_side    = side_ff;

endmodule

### rtl/core/ppam_div_step.sv
module ppam_div_step import ppam_pkg::*; #(
   parameter int PW = 35,
   parameter int SH = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [PW-1:0]       in_rcol,
   input  logic [PW-1:0]       in_rrow,
   input  logic [PW-1:0]       in_den,
   input  logic [COORD_BITS:0] in_qcol,
   input  logic [COORD_BITS:0] in_qrow,
   input  ppam_side_type       in_side,
   output logic                out_vld,
   output logic [PW-1:0]       out_rcol,
   output logic [PW-1:0]       out_rrow,
   output logic [PW-1:0]       out_den,
   output logic [COORD_BITS:0] out_qcol,
   output logic [COORD_BITS:0] out_qrow,
   output ppam_side_type       out_side
);

   localparam int EW = PW + COORD_BITS;

   logic [EW-1:0]       dsh, rcol_x, rrow_x;
   logic                take_col, take_row;
   logic                vld_ff;
   logic [PW-1:0]       rcol_in, rrow_in, rcol_ff, rrow_ff, den_ff;
   logic [COORD_BITS:0] qcol_in, qrow_in, qcol_ff, qrow_ff;
   ppam_side_type       side_ff;

   // one restoring step per lane at weight 2^SH
   always_comb begin
      dsh      = EW'(in_den) << SH;
      rcol_x   = EW'(in_rcol);
      rrow_x   = EW'(in_rrow);
      take_col = (rcol_x >= dsh);
      take_row = (rrow_x >= dsh);
      rcol_in  = take_col ? PW'(rcol_x - dsh) : in_rcol;
      rrow_in  = take_row ? PW'(rrow_x - dsh) : in_rrow;
      qcol_in  = in_qcol;
      qrow_in  = in_qrow;
      qcol_in[SH] = take_col;
      qrow_in[SH] = take_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rcol_ff <= rcol_in;
         rrow_ff <= rrow_in;
         den_ff  <= in_den;
         qcol_ff <= qcol_in;
         qrow_ff <= qrow_in;
         side_ff <= in_side;
      end
   end

   assign out_vld  = vld_ff;
   assign out_rcol = rcol_ff;
   assign out_rrow = rrow_ff;
   assign out_den  = den_ff;
   assign out_qcol = qcol_ff;
   assign out_qrow = qrow_ff;
   assign out_side = side_ff;

endmodule

### rtl/core/projective_pixel_address_map.sv
// Channel | Ports                               | Moves
// req     | req_valid, req_stall, req_data      | one pixel coordinate per transfer
// rsp     | rsp_valid, rsp_stall, rsp_data      | one mapped address per transfer
// csr     | csr_we, csr_index, csr_wdata        | register write, no wait
//
// Three stages for products, sums and sign handling, COORD_BITS + 1 divider
// steps and one output stage. One transfer per cycle is sustained while no
// result waits under rsp_stall; the divider retires one quotient bit per
// stage for both lanes.
// Synchronous reset empties the pipeline and loads the identity matrix,
// 640 x 480, inverse mode.
// The whole pipeline holds while a result waits under rsp_stall; req_stall
// follows that condition.
module projective_pixel_address_map import ppam_pkg::*; #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ppam_req_type                        req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ppam_rsp_type                        rsp_data,
   input  logic                                csr_we,
   input  logic [CSR_IDX_BITS-1:0]             csr_index,
   input  logic [3*(COEF_FRAC_BITS+5)-1:0]     csr_wdata
);

   localparam int CW = COEF_FRAC_BITS + 5;
   localparam int RW = 3 * CW;
   localparam int PW = CW + COORD_BITS + 2;
   localparam int QW = COORD_BITS + 1;
   localparam int NS = COORD_BITS + 1;

   logic [RW-1:0]        row0_ff, row1_ff, row2_ff;
   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic                 dir_ff;
   logic                 en;

   logic [PW-1:0]        rcol [NS+1];
   logic [PW-1:0]        rrow [NS+1];
   logic [PW-1:0]        den  [NS+1];
   logic [QW-1:0]        qcol [NS+1];
   logic [QW-1:0]        qrow [NS+1];
   ppam_side_type        side [NS+1];
   logic                 vld  [NS+1];

   logic [COORD_BITS-1:0] cmax, rmax, mc, mr;
   logic                  out_vld_ff;
   ppam_rsp_type          out_ff, out_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff   <= RW'(1) << COEF_FRAC_BITS;
         row1_ff   <= RW'(1) << (COEF_FRAC_BITS + CW);
         row2_ff   <= RW'(1) << (COEF_FRAC_BITS + 2*CW);
         width_ff  <= SIZE_BITS'(640);
         height_ff <= SIZE_BITS'(480);
         dir_ff    <= DIR_INVERSE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW0:   row0_ff   <= csr_wdata;
            CSR_ROW1:   row1_ff   <= csr_wdata;
            CSR_ROW2:   row2_ff   <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata[SIZE_BITS-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_DIR:    dir_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // global advance: hold only when the output slot is full and stalled
   assign en        = !(out_vld_ff && rsp_stall);
   assign req_stall = !en;

   ppam_proj #(.CW(CW), .PW(PW)) u_proj (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_vld      (req_valid),
      .in_data     (req_data),
      .coef0       (row0_ff),
      .coef1       (row1_ff),
      .coef2       (row2_ff),
      .out_vld     (vld[0]),
      .out_abs_col (rcol[0]),
      .out_abs_row (rrow[0]),
      .out_abs_den (den[0]),
      .out_side    (side[0])
   );

   assign qcol[0] = '0;
   assign qrow[0] = '0;

   // divider: top step tests quotient >= 2^COORD_BITS
   for (genvar k = 0; k < NS; k++) begin : g_div
      ppam_div_step #(.PW(PW), .SH(NS-1-k)) u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (vld[k]),
         .in_rcol  (rcol[k]),
         .in_rrow  (rrow[k]),
         .in_den   (den[k]),
         .in_qcol  (qcol[k]),
         .in_qrow  (qrow[k]),
         .in_side  (side[k]),
         .out_vld  (vld[k+1]),
         .out_rcol (rcol[k+1]),
         .out_rrow (rrow[k+1]),
         .out_den  (den[k+1]),
         .out_qcol (qcol[k+1]),
         .out_qrow (qrow[k+1]),
         .out_side (side[k+1])
      );
   end

   // clamp bounds: size 0 acts as 1, above 2^COORD_BITS acts as 2^COORD_BITS
   always_comb begin
      if (width_ff == '0)
         cmax = '0;
      else if (width_ff[COORD_BITS] && (width_ff[COORD_BITS-1:0] != '0))
         cmax = '1;
      else
         cmax = COORD_BITS'(width_ff - SIZE_BITS'(1));
      if (height_ff == '0)
         rmax = '0;
      else if (height_ff[COORD_BITS] && (height_ff[COORD_BITS-1:0] != '0))
         rmax = '1;
      else
         rmax = COORD_BITS'(height_ff - SIZE_BITS'(1));
   end

   // clamp and border flag
   always_comb begin
      if (side[NS].col_lo)
         mc = '0;
      else if (side[NS].col_hi || qcol[NS][COORD_BITS]
               || (qcol[NS][COORD_BITS-1:0] > cmax))
         mc = cmax;
      else
         mc = qcol[NS][COORD_BITS-1:0];
      if (side[NS].row_lo)
         mr = '0;
      else if (side[NS].row_hi || qrow[NS][COORD_BITS]
               || (qrow[NS][COORD_BITS-1:0] > rmax))
         mr = rmax;
      else
         mr = qrow[NS][COORD_BITS-1:0];
      out_in.mapped_row = mr;
      out_in.mapped_col = mc;
      out_in.write_zero = (dir_ff == DIR_INVERSE)
                        && (mr == '0 || mr == rmax || mc == '0 || mc == cmax);
      out_in.denom_zero = side[NS].denom_zero;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

### rtl/core/ppam_checker.sv
module ppam_checker import ppam_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input ppam_rsp_type rsp_data
);

   // input holds only behind a stalled, waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled result");

   // a result never appears right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid right after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // a held result keeps the input side stalled
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output held");

endmodule

bind projective_pixel_address_map ppam_checker u_ppam_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
